FILE: rtl/core/hts_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Timer heap package
// Shared codes and widths for the heap timer scheduler.
// -----------------------------------------------------------------------------
package hts_pkg;
	localparam int EXP_W = 48;
	localparam int TMO_W = 31;
	localparam int NXT_W = 32;
	localparam int MODE_W = 3;
	localparam int STAT_W = 2;

	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADJUST = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIRE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	localparam logic KIND_NOTICE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};
	localparam logic [NXT_W-1:0] NXT_EMPTY = {NXT_W{1'b1}};
	localparam logic [NXT_W-1:0] NXT_CAP = {1'b0, {(NXT_W-1){1'b1}}};

	// Compare unit result: a <= b and a < b
	typedef struct packed {
		logic le;
		logic lt;
	} cmp_res_t;
endpackage

FILE: rtl/core/hts_cmp.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Expiry comparator
// Shared 48-bit magnitude compare used for every heap ordering decision.
// -----------------------------------------------------------------------------
module hts_cmp import hts_pkg::*; (
	input  logic [EXP_W-1:0] a,
	input  logic [EXP_W-1:0] b,
	output cmp_res_t         res
);
	// Compare operands
	always_comb begin
		res.lt = a < b;
		res.le = a <= b;
	end
endmodule

FILE: rtl/core/heap_timer_scheduler_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Heap timer scheduler
// Min-heap timer queue with an id-to-slot map, run by a small sequencer.
// -----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction (mode, timer id, timeout,
//   current time). m_axis returns zero or more expiry notices (tuser = 0)
//   followed by one status transaction (tuser = 1, tlast = 1).
//   Every ordering decision goes through one shared expiry comparator, one
//   heap step per cycle. A new item is taken only after the status
//   transaction of the previous one has been accepted. A sift down
//   compares the two children and then the parent with the smaller child
//   at each level; a sift up compares each entry with its parent. A tick
//   removes every expired entry in turn, sending a notice for each.
//   s_axis_tready is high only while the sequencer is idle.
//   After reset the queue is empty; reset first sweeps the id map, entry
//   by entry, and no item is accepted during the sweep. A clear operation runs
//   the same sweep. When the receiver stalls, the sequencer holds its result
//   in the output register and waits.
// -----------------------------------------------------------------------------
module heap_timer_scheduler_unit import hts_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int ID_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: mode[2:0], timer_id[10:3], timeout_ms[41:11], now_ms[89:42], zero pad
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: expired_id[7:0], status[9:8], next_ms[41:10], zero pad
	output logic [47:0] m_axis_tdata,
	// tuser: kind
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);
	localparam int SW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int IW = $clog2(ID_COUNT);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DECODE, S_NOTICE, S_REMOVE, S_SD_A, S_SD_B, S_SD_C,
		S_SU_A, S_SU_B, S_TICK, S_STATUS, S_WAIT
	} state_t;

	state_t state_q, after_q;
	logic [EXP_W-1:0] exp_q [CAPACITY];
	logic [7:0] hid_q [CAPACITY];
	logic [SW-1:0] map_q [ID_COUNT];
	logic map_v_q [ID_COUNT];
	logic [SW-1:0] cnt_q, i_q, c_q, start_q;
	logic [IW-1:0] clr_q;
	logic [MODE_W-1:0] mode_q;
	logic [7:0] id_q;
	logic [EXP_W-1:0] now_q, newexp_q;
	logic [STAT_W-1:0] st_q;
	logic moved_q;
	logic [EXP_W-1:0] ca, cb;
	cmp_res_t cr;
	logic [EXP_W:0] sum;
	logic known;
	logic [SW-1:0] kslot_q;
	logic [IW-1:0] id_ix;
	logic id_ok;
	logic [EXP_W-1:0] diff;
	logic [SW-1:0] par;
	logic [AW-1:0] ix_i, ix_c, ix_c1, ix_p, ix_l, ix_n, ix_k;

	hts_cmp u_cmp (.a(ca), .b(cb), .res(cr));

	// Decode the input item
	assign sum = {1'b0, s_axis_tdata[89:42]} + {{(EXP_W-TMO_W+1){1'b0}}, s_axis_tdata[41:11]};
	assign id_ok = (32'(id_q) < 32'(ID_COUNT));
	assign id_ix = IW'(id_q);
	assign known = id_ok && map_v_q[id_ix];
	assign diff = exp_q[0] - now_q;

	// Heap slot indexes for the current step
	assign par = (i_q - SW'(1)) >> 1;
	assign ix_i = AW'(i_q);
	assign ix_c = AW'(c_q);
	assign ix_c1 = AW'(c_q + SW'(1));
	assign ix_p = AW'(par);
	assign ix_l = AW'(cnt_q - SW'(1));
	assign ix_n = AW'(cnt_q);
	assign ix_k = AW'(kslot_q);

	// Select compare operands for the current step
	always_comb begin
		ca = exp_q[0];
		cb = now_q;
		case (state_q)
			S_SD_A: begin ca = exp_q[ix_c1]; cb = exp_q[ix_c]; end
			S_SD_B: begin ca = exp_q[ix_i]; cb = exp_q[ix_c]; end
			S_SU_A: begin ca = exp_q[ix_p]; cb = exp_q[ix_i]; end
			default: begin ca = exp_q[0]; cb = now_q; end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);

	// Sequencer, heap store and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			after_q <= S_IDLE;
			clr_q <= '0;
			cnt_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					map_v_q[clr_q] <= 1'b0;
					clr_q <= clr_q + IW'(1);
					if ({1'b0, clr_q} == (IW+1)'(ID_COUNT - 1)) state_q <= after_q;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						mode_q <= s_axis_tdata[2:0];
						id_q <= s_axis_tdata[10:3];
						now_q <= s_axis_tdata[89:42];
						newexp_q <= sum[EXP_W] ? EXP_MAX : sum[EXP_W-1:0];
						kslot_q <= map_q[IW'(s_axis_tdata[10:3])];
						st_q <= ST_OK;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (mode_q)
						MODE_ADD, MODE_ADJUST: begin
							if (!id_ok) begin
								st_q <= ST_UNKNOWN;
								state_q <= S_STATUS;
							end else if (known) begin
								exp_q[ix_k] <= newexp_q;
								i_q <= kslot_q;
								start_q <= kslot_q;
								c_q <= SW'({kslot_q, 1'b1});
								state_q <= S_SD_A;
							end else if (mode_q == MODE_ADJUST) begin
								st_q <= ST_UNKNOWN;
								state_q <= S_STATUS;
							end else if ({1'b0, cnt_q} >= (SW+1)'(CAPACITY)) begin
								st_q <= ST_FULL;
								state_q <= S_STATUS;
							end else begin
								exp_q[ix_n] <= newexp_q;
								hid_q[ix_n] <= id_q;
								map_q[id_ix] <= cnt_q;
								map_v_q[id_ix] <= 1'b1;
								cnt_q <= cnt_q + SW'(1);
								i_q <= cnt_q;
								state_q <= S_SU_A;
							end
						end
						MODE_FIRE: begin
							if (known) begin
								i_q <= kslot_q;
								state_q <= S_NOTICE;
							end else state_q <= S_STATUS;
						end
						MODE_TICK: state_q <= S_TICK;
						MODE_POP: begin
							i_q <= '0;
							state_q <= (cnt_q != '0) ? S_REMOVE : S_STATUS;
						end
						MODE_CLEAR: begin
							cnt_q <= '0;
							clr_q <= '0;
							after_q <= S_STATUS;
							state_q <= S_CLR;
						end
						default: state_q <= S_STATUS;
					endcase
				end
				S_TICK: begin
					if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
					if (cnt_q != '0 && cr.le) begin
						i_q <= '0;
						id_q <= hid_q[0];
						state_q <= S_NOTICE;
					end else state_q <= S_STATUS;
				end
				S_NOTICE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser <= KIND_NOTICE;
						m_axis_tlast <= 1'b0;
						m_axis_tdata <= {6'd0, 32'd0, ST_OK, id_q};
						state_q <= S_REMOVE;
					end
				end
				S_REMOVE: begin
					if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
					// drop the removed id, move the last entry into slot i
					map_v_q[IW'(hid_q[ix_i])] <= 1'b0;
					if (i_q != cnt_q - SW'(1)) begin
						exp_q[ix_i] <= exp_q[ix_l];
						hid_q[ix_i] <= hid_q[ix_l];
						map_q[IW'(hid_q[ix_l])] <= i_q;
						start_q <= i_q;
						c_q <= SW'({i_q, 1'b1});
						state_q <= S_SD_A;
					end else state_q <= (mode_q == MODE_TICK) ? S_TICK : S_STATUS;
					cnt_q <= cnt_q - SW'(1);
				end
				S_SD_A: begin
					if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
					if (c_q >= cnt_q || c_q < i_q) begin
						moved_q <= (i_q != start_q);
						state_q <= S_SD_C;
					end else begin
						if (c_q + SW'(1) < cnt_q && cr.lt) c_q <= c_q + SW'(1);
						state_q <= S_SD_B;
					end
				end
				S_SD_B: begin
					if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
					if (cr.le) begin
						moved_q <= (i_q != start_q);
						state_q <= S_SD_C;
					end else begin
						exp_q[ix_i] <= exp_q[ix_c];
						hid_q[ix_i] <= hid_q[ix_c];
						exp_q[ix_c] <= exp_q[ix_i];
						hid_q[ix_c] <= hid_q[ix_i];
						map_q[IW'(hid_q[ix_c])] <= i_q;
						map_q[IW'(hid_q[ix_i])] <= c_q;
						i_q <= c_q;
						c_q <= SW'({c_q, 1'b1});
						state_q <= S_SD_A;
					end
				end
				S_SD_C: begin
					if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
					i_q <= start_q;
					if (moved_q) state_q <= (mode_q == MODE_TICK) ? S_TICK : S_STATUS;
					else state_q <= S_SU_A;
				end
				S_SU_A: begin
					if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
					if (i_q == '0 || cr.le) state_q <= (mode_q == MODE_TICK) ? S_TICK : S_STATUS;
					else begin
						exp_q[ix_i] <= exp_q[ix_p];
						hid_q[ix_i] <= hid_q[ix_p];
						exp_q[ix_p] <= exp_q[ix_i];
						hid_q[ix_p] <= hid_q[ix_i];
						map_q[IW'(hid_q[ix_p])] <= i_q;
						map_q[IW'(hid_q[ix_i])] <= par;
						i_q <= par;
					end
				end
				S_STATUS: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser <= KIND_STATUS;
						m_axis_tlast <= 1'b1;
						if (cnt_q == '0)
							m_axis_tdata <= {6'd0, NXT_EMPTY, st_q, 8'd0};
						else if (cr.le)
							m_axis_tdata <= {6'd0, 32'd0, st_q, 8'd0};
						else if (diff[EXP_W-1:NXT_W-1] != '0)
							m_axis_tdata <= {6'd0, NXT_CAP, st_q, 8'd0};
						else
							m_axis_tdata <= {6'd0, diff[NXT_W-1:0], st_q, 8'd0};
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
